>>> hw/rtl/acf_pkg.sv
// ----------------------------------------------------------------------------
// ADC channel filter package
// Item types, kind codes, sizing constants and the debounce helper shared by
// the ADC channel filter blocks.
// ----------------------------------------------------------------------------
package acf_pkg;

    localparam int CHANNELS   = 8;
    localparam int COUNT_BITS = 16;

    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int LIMIT_W    = 16;
    localparam int TICKS_W    = 15;
    localparam int ACC_W      = 32;
    localparam int SHIFT_W    = 4;
    localparam int SHIFTS_W   = 32;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_CMP_W   = 5;
    // wide enough for minus the largest tick count and for the counter minimum
    localparam int CMP_W      = ((COUNT_BITS > TICKS_W + 1) ? COUNT_BITS : TICKS_W + 1) + 1;

    typedef logic signed [COUNT_BITS-1:0] t_cnt;

    localparam t_cnt CNT_MAX  = t_cnt'({1'b0, {(COUNT_BITS-1){1'b1}}});
    localparam t_cnt CNT_MIN  = t_cnt'({1'b1, {(COUNT_BITS-1){1'b0}}});
    localparam t_cnt CNT_ZERO = t_cnt'(0);
    localparam t_cnt CNT_ONE  = t_cnt'(1);
    localparam logic signed [CMP_W-1:0] CNT_MIN_EXT =
        -$signed(CMP_W'(64'd1 << (COUNT_BITS - 1)));

    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_WR_UPPER = 2'd1,
        KIND_WR_LOWER = 2'd2,
        KIND_INHIBIT  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CH_W-1:0]      channel;
        logic [SAMPLE_W-1:0]  sample;
        logic                 hold_filter;
        logic [LIMIT_W-1:0]   alert_limit;
        logic                 alert_enable;
        logic [TICKS_W-1:0]   inhibit_ticks;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]      result_channel;
        logic [SAMPLE_W-1:0]  average;
        logic                 upper_alert;
        logic                 lower_alert;
    } t_out_item;

    typedef struct packed {
        t_cnt cnt;
        logic fire;
    } t_deb;

    // Bump the counter (saturating), then fire or clear a positive count.
    function automatic t_deb debounce(input t_cnt cnt, input logic on, input logic met);
        t_deb r;
        r.cnt  = (cnt < CNT_MAX) ? t_cnt'(cnt + CNT_ONE) : cnt;
        r.fire = 1'b0;
        if (on && met) begin
            r.fire = (r.cnt > CNT_ONE);
        end else if (r.cnt > CNT_ZERO) begin
            r.cnt = CNT_ZERO;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/adc_channel_filter_with_alerts_core.sv
// ----------------------------------------------------------------------------
// ADC channel filter with alerts
// Per-channel exponential moving average with debounced upper/lower alerts.
//
//   port group    dir  handshake                 payload
//   input item    in   i_in_valid / o_in_ready   i_in_item  (t_in_item)
//   result item   out  o_out_valid / i_out_ready o_out_item (t_out_item)
//   shift config  in   i_cfg_we                  i_cfg_wdata (32 bits)
//
// One item per cycle while the result is not stalled; an accepted item passes
// through the input register, then the channel read-modify-write into the
// result register.
// Synchronous active-low reset clears all channel state and the shift register.
// A stalled result holds the result register; the input register still takes
// one more item if it is empty, then ready drops until the result is taken.
// ----------------------------------------------------------------------------
module adc_channel_filter_with_alerts_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  acf_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output acf_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_we,
    input  logic [acf_pkg::SHIFTS_W-1:0] i_cfg_wdata
);
    import acf_pkg::*;

    logic [SHIFTS_W-1:0] r_shifts;
    logic                r_out_valid;
    logic                n_out_valid;
    t_out_item           r_out_item;

    logic      st_valid;
    t_in_item  st_item;
    logic      out_free;
    logic      take;
    t_out_item res;

    assign out_free = !r_out_valid || i_out_ready;
    assign take     = st_valid && out_free;

    acf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (take)
    );

    acf_chan_dp u_chan_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shifts (r_shifts),
        .i_item   (st_item),
        .i_commit (take),
        .o_res    (res)
    );

    assign n_out_valid = take || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_shifts <= i_cfg_wdata;
            end
        end
    end

    // Load the result only when the item moves out of the input register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (st_valid && r_out_valid && !i_out_ready))
        else $error("input stalled while the pipeline had room");

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_out_valid)
        else $error("committed item produced no result");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !take) |=> !o_out_valid)
        else $error("result repeated after being taken");

endmodule

>>> hw/rtl/acf_in_reg.sv
// ----------------------------------------------------------------------------
// ADC channel filter input register
// One-entry input stage; refills in the same cycle the held item moves on.
// ----------------------------------------------------------------------------
module acf_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  acf_pkg::t_in_item i_item,
    output logic              o_valid,
    output acf_pkg::t_in_item o_item,
    input  logic              i_take
);
    import acf_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hw/rtl/acf_chan_dp.sv
// ----------------------------------------------------------------------------
// ADC channel filter datapath
// Per-channel accumulators, limits and debounce counters; one read-modify-
// write per committed in-range item, with the result formed in the same cycle.
// ----------------------------------------------------------------------------
module acf_chan_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [acf_pkg::SHIFTS_W-1:0] i_shifts,
    input  acf_pkg::t_in_item          i_item,
    input  logic                       i_commit,
    output acf_pkg::t_out_item         o_res
);
    import acf_pkg::*;

    logic [ACC_W-1:0]   r_acc    [CHANNELS];
    logic [LIMIT_W-1:0] r_up_lim [CHANNELS];
    logic [LIMIT_W-1:0] r_lo_lim [CHANNELS];
    logic               r_up_on  [CHANNELS];
    logic               r_lo_on  [CHANNELS];
    t_cnt               r_up_cnt [CHANNELS];
    t_cnt               r_lo_cnt [CHANNELS];

    logic [CH_IDX_W-1:0]  idx;
    logic                 ch_ok;
    logic [SHIFT_W-1:0]   sh;
    logic [ACC_W-1:0]     acc;
    logic [ACC_W-1:0]     n_acc;
    logic                 is_sample;
    t_deb                 up_deb;
    t_deb                 lo_deb;
    logic signed [CMP_W-1:0] neg_ticks;
    t_cnt                 inh_cnt;

    assign idx       = CH_IDX_W'(i_item.channel);
    assign ch_ok     = (CH_CMP_W'(i_item.channel) < CH_CMP_W'(CHANNELS));
    assign sh        = i_shifts[{i_item.channel, 2'b00} +: SHIFT_W];
    assign acc       = r_acc[idx];
    assign is_sample = (i_item.kind == KIND_SAMPLE);

    always_comb begin
        n_acc = acc;
        if (is_sample && !i_item.hold_filter) begin
            n_acc = ACC_W'(i_item.sample) + acc - (acc >> sh);
        end
    end

    assign up_deb = debounce(r_up_cnt[idx], r_up_on[idx], i_item.sample >= r_up_lim[idx]);
    assign lo_deb = debounce(r_lo_cnt[idx], r_lo_on[idx], i_item.sample <= r_lo_lim[idx]);

    // Preload minus the tick count, clamped to the counter minimum.
    assign neg_ticks = -$signed({{(CMP_W-TICKS_W){1'b0}}, i_item.inhibit_ticks});
    assign inh_cnt   = (neg_ticks < CNT_MIN_EXT) ? CNT_MIN : t_cnt'(neg_ticks);

    always_comb begin
        o_res.result_channel = i_item.channel;
        o_res.average        = '0;
        o_res.upper_alert    = 1'b0;
        o_res.lower_alert    = 1'b0;
        if (ch_ok) begin
            o_res.average = SAMPLE_W'(n_acc >> sh);
            if (is_sample) begin
                o_res.upper_alert = up_deb.fire;
                o_res.lower_alert = lo_deb.fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_acc[i]    <= '0;
                r_up_lim[i] <= '0;
                r_lo_lim[i] <= '0;
                r_up_on[i]  <= 1'b0;
                r_lo_on[i]  <= 1'b0;
                r_up_cnt[i] <= CNT_ZERO;
                r_lo_cnt[i] <= CNT_ZERO;
            end
        end else if (i_commit && ch_ok) begin
            case (i_item.kind)
                KIND_SAMPLE: begin
                    r_acc[idx]    <= n_acc;
                    r_up_cnt[idx] <= up_deb.cnt;
                    r_lo_cnt[idx] <= lo_deb.cnt;
                end
                KIND_WR_UPPER: begin
                    r_up_lim[idx] <= i_item.alert_limit;
                    r_up_on[idx]  <= i_item.alert_enable;
                end
                KIND_WR_LOWER: begin
                    r_lo_lim[idx] <= i_item.alert_limit;
                    r_lo_on[idx]  <= i_item.alert_enable;
                end
                KIND_INHIBIT: begin
                    r_up_cnt[idx] <= inh_cnt;
                end
                default: begin
                end
            endcase
        end
    end

    a_no_alert_off_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && !is_sample) |-> (!o_res.upper_alert && !o_res.lower_alert))
        else $error("alert raised on a non-sample item");

    a_inhibit_nonpositive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && ch_ok && (i_item.kind == KIND_INHIBIT))
        |=> (r_up_cnt[$past(idx)] <= CNT_ZERO))
        else $error("inhibit left a positive upper counter");

    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && !ch_ok) |-> (o_res.average == '0))
        else $error("out-of-range channel reported a nonzero average");

endmodule

>>> dv/adc_channel_filter_with_alerts_core_test.sv
// ----------------------------------------------------------------------------
// ADC channel filter with alerts - block test
// Drives sample, limit-write and inhibit items through the valid/ready ports
// under random sender and receiver stalls. A scoreboard class tracks the
// per-channel accumulators and debounce counters, predicts each result item,
// and compares the block's results field by field in order.
// ----------------------------------------------------------------------------
module adc_channel_filter_with_alerts_core_test;

    import acf_pkg::*;

    localparam longint CNT_TOP         = (64'sd1 <<< (COUNT_BITS - 1)) - 1;
    localparam longint CNT_BOTTOM      = -CNT_TOP - 1;
    localparam int     LIMIT_CYCLES    = 500000;
    localparam int     HOLD_OFF_CYCLES = 200;
    localparam int     LATENCY_PAD     = 4;
    localparam int     MET_RUN_LEN     = 40;

    class filter_alert_scoreboard;
        logic [SHIFTS_W-1:0] shift_cfg;
        logic [ACC_W-1:0]    accum    [CHANNELS];
        logic [LIMIT_W-1:0]  hi_limit [CHANNELS];
        logic [LIMIT_W-1:0]  lo_limit [CHANNELS];
        bit                  hi_on    [CHANNELS];
        bit                  lo_on    [CHANNELS];
        longint              hi_count [CHANNELS];
        longint              lo_count [CHANNELS];
        t_out_item           pending_results [$];
        int                  errors;

        function new();
            shift_cfg = '0;
            errors    = 0;
            foreach (accum[c]) begin
                accum[c]    = '0;
                hi_limit[c] = '0;
                lo_limit[c] = '0;
                hi_on[c]    = 1'b0;
                lo_on[c]    = 1'b0;
                hi_count[c] = 0;
                lo_count[c] = 0;
            end
        endfunction

        // Advance one debounce counter; return 1 when the alert fires.
        function bit bump_counter(inout longint cnt, input bit armed, input bit met);
            if (cnt < CNT_TOP) cnt++;
            if (armed && met) return (cnt > 1);
            if (cnt > 0) cnt = 0;
            return 1'b0;
        endfunction

        function void note_item(t_in_item it);
            t_out_item want;
            int        ch;
            int        sh;
            longint    preload;
            want                = '0;
            want.result_channel = it.channel;
            ch                  = int'(it.channel);
            if (ch < CHANNELS) begin
                sh = int'(shift_cfg[SHIFT_W*ch +: SHIFT_W]);
                case (it.kind)
                    KIND_SAMPLE: begin
                        if (!it.hold_filter) begin
                            accum[ch] = ACC_W'(it.sample) + accum[ch] - (accum[ch] >> sh);
                        end
                        want.upper_alert = bump_counter(hi_count[ch], hi_on[ch],
                                                        it.sample >= hi_limit[ch]);
                        want.lower_alert = bump_counter(lo_count[ch], lo_on[ch],
                                                        it.sample <= lo_limit[ch]);
                    end
                    KIND_WR_UPPER: begin
                        hi_limit[ch] = it.alert_limit;
                        hi_on[ch]    = it.alert_enable;
                    end
                    KIND_WR_LOWER: begin
                        lo_limit[ch] = it.alert_limit;
                        lo_on[ch]    = it.alert_enable;
                    end
                    KIND_INHIBIT: begin
                        preload      = -longint'(it.inhibit_ticks);
                        hi_count[ch] = (preload < CNT_BOTTOM) ? CNT_BOTTOM : preload;
                    end
                    default: ;
                endcase
                want.average = SAMPLE_W'(accum[ch] >> sh);
            end
            pending_results.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result_channel !== want.result_channel) begin
                $error("result_channel: expected %0d, got %0d",
                       want.result_channel, got.result_channel);
                errors++;
            end
            if (got.average !== want.average) begin
                $error("average: expected %h, got %h", want.average, got.average);
                errors++;
            end
            if (got.upper_alert !== want.upper_alert) begin
                $error("upper_alert: expected %b, got %b", want.upper_alert, got.upper_alert);
                errors++;
            end
            if (got.lower_alert !== want.lower_alert) begin
                $error("lower_alert: expected %b, got %b", want.lower_alert, got.lower_alert);
                errors++;
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_in_item            in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_item;
    logic                cfg_we    = 1'b0;
    logic [SHIFTS_W-1:0] cfg_wdata = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_off_req  = 1'b0;
    int          cycle_count   = 0;

    filter_alert_scoreboard sb;

    adc_channel_filter_with_alerts_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("adc_channel_filter_with_alerts_core_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_item(in_item);
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
    end

    // Receiver: random stalls, or one long hold-off when requested.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_in_item make_item(t_kind k, logic [CH_W-1:0] ch,
                                           logic [SAMPLE_W-1:0] smp, logic hold,
                                           logic [LIMIT_W-1:0] lim, logic en,
                                           logic [TICKS_W-1:0] ticks);
        t_in_item it;
        it.kind          = k;
        it.channel       = ch;
        it.sample        = smp;
        it.hold_filter   = hold;
        it.alert_limit   = lim;
        it.alert_enable  = en;
        it.inhibit_ticks = ticks;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        return make_item(t_kind'($urandom_range(3)), CH_W'($urandom), SAMPLE_W'($urandom),
                         1'($urandom), LIMIT_W'($urandom), 1'($urandom), TICKS_W'($urandom));
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit(bit upper);
        logic [LIMIT_W-1:0] v;
        v = LIMIT_W'($urandom);
        if ($urandom_range(7) == 0) return v;
        return upper ? (v | 16'h8000) : (v & 16'h7FFF);
    endfunction

    // Aim samples at and around the channel's current limits, plus full-scale and random values.
    function automatic logic [SAMPLE_W-1:0] probe_sample(int ch);
        case ($urandom_range(7))
            0:       return sb.hi_limit[ch] + SAMPLE_W'($urandom_range(3));
            1:       return sb.hi_limit[ch] - 1'b1;
            2:       return sb.lo_limit[ch] - SAMPLE_W'($urandom_range(3));
            3:       return sb.lo_limit[ch] + 1'b1;
            4:       return '0;
            5:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic write_shifts(input logic [SHIFTS_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.shift_cfg = v;
    endtask

    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Mostly limit setup, inhibit and sample runs on one channel; the rest is noise.
    task automatic run_random(input int count);
        int sent;
        int ch;
        int run_len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 20) begin
                send_item(noise_item());
                sent++;
            end else begin
                ch = $urandom_range(CHANNELS - 1);
                if ($urandom_range(2) == 0) begin
                    send_item(make_item(KIND_WR_UPPER, CH_W'(ch), SAMPLE_W'($urandom),
                                        1'($urandom), pick_limit(1'b1),
                                        $urandom_range(7) != 0, TICKS_W'($urandom)));
                    send_item(make_item(KIND_WR_LOWER, CH_W'(ch), SAMPLE_W'($urandom),
                                        1'($urandom), pick_limit(1'b0),
                                        $urandom_range(7) != 0, TICKS_W'($urandom)));
                    sent += 2;
                end
                if ($urandom_range(2) == 0) begin
                    send_item(make_item(KIND_INHIBIT, CH_W'(ch), SAMPLE_W'($urandom),
                                        1'($urandom), LIMIT_W'($urandom), 1'($urandom),
                                        TICKS_W'($urandom_range(4))));
                    sent++;
                end
                run_len = $urandom_range(12, 2);
                for (int k = 0; k < run_len; k++) begin
                    send_item(make_item(KIND_SAMPLE, CH_W'(ch), probe_sample(ch),
                                        $urandom_range(7) == 0, LIMIT_W'($urandom),
                                        1'($urandom), TICKS_W'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    task automatic run_directed();
        send_item(make_item(KIND_SAMPLE,   3'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd7, 16'h0000, 1'b1, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_WR_UPPER, 3'd1, 16'h0000, 1'b0, 16'h8000, 1'b1, 15'd0));
        send_item(make_item(KIND_WR_LOWER, 3'd1, 16'h0000, 1'b0, 16'h1000, 1'b1, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd1, 16'h8000, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 15'd0));
        // rewrite the limit: the running count must survive
        send_item(make_item(KIND_WR_UPPER, 3'd1, 16'h0000, 1'b0, 16'h9000, 1'b1, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd1, 16'h9000, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd1, 16'h0800, 1'b1, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd1, 16'h1000, 1'b0, 16'h0000, 1'b0, 15'd0));
        // suppress the upper alert with a preload of three
        send_item(make_item(KIND_INHIBIT,  3'd1, 16'h0000, 1'b0, 16'h0000, 1'b0, 15'd3));
        repeat (5) begin
            send_item(make_item(KIND_SAMPLE, 3'd1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 15'd0));
        end
        send_item(make_item(KIND_WR_UPPER, 3'd1, 16'h0000, 1'b0, 16'hFFFF, 1'b0, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_INHIBIT,  3'd2, 16'h0000, 1'b0, 16'h0000, 1'b0, 15'h7FFF));
        send_item(make_item(KIND_WR_LOWER, 3'd3, 16'h0000, 1'b0, 16'hFFFF, 1'b1, 15'd0));
        send_item(make_item(KIND_WR_UPPER, 3'd3, 16'h0000, 1'b0, 16'h0000, 1'b1, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd3, 16'h0000, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd3, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_INHIBIT,  3'd4, 16'h0000, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_item(make_item(KIND_SAMPLE,   3'd6, 16'h7FFF, 1'b0, 16'h0000, 1'b0, 15'd0));
    endtask

    // Hold both alerts of one channel met over a long run of samples.
    task automatic run_held_alerts(input int ch);
        send_item(make_item(KIND_WR_UPPER, CH_W'(ch), '0, 1'b0, 16'h0000, 1'b1, '0));
        send_item(make_item(KIND_WR_LOWER, CH_W'(ch), '0, 1'b0, 16'hFFFF, 1'b1, '0));
        repeat (MET_RUN_LEN) begin
            send_item(make_item(KIND_SAMPLE, CH_W'(ch), SAMPLE_W'($urandom),
                                1'($urandom), '0, 1'b0, '0));
        end
        send_item(make_item(KIND_WR_UPPER, CH_W'(ch), '0, 1'b0, 16'h0000, 1'b0, '0));
        send_item(make_item(KIND_SAMPLE,   CH_W'(ch), 16'h1234, 1'b0, '0, 1'b0, '0));
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(12, 50);
        run_directed();
        wait_results_drained();

        write_shifts(32'hFFFF_FFFF);
        run_random(150);
        wait_results_drained();
        write_shifts(SHIFTS_W'($urandom));
        run_random(300);
        wait_results_drained();

        set_idle(50, 12);
        write_shifts(32'h0123_4567);
        run_random(150);
        wait_results_drained();
        run_random(150);
        wait_results_drained();

        set_idle(0, 0);
        write_shifts(32'hFEDC_BA98);
        hold_off_req = 1'b1;
        run_random(300);
        wait_results_drained();
        write_shifts('0);
        run_random(350);
        wait_results_drained();

        write_shifts(SHIFTS_W'($urandom));
        run_held_alerts($urandom_range(CHANNELS - 1));
        wait_results_drained();

        if (sb.errors == 0) begin
            $display("adc_channel_filter_with_alerts_core_test: PASS");
        end else begin
            $display("adc_channel_filter_with_alerts_core_test: FAIL");
        end
        $finish;
    end

endmodule
